### src/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the greedy rainbow matching block.
// ----------------------------------------------------------------------------
package grm_pkg;

	// Table sizes are powers of two, so indices reduce by dropping high bits
	localparam int VERTEX_COUNT = 65536;
	localparam int COLOR_COUNT  = 1024;
	localparam int VTX_W        = $clog2(VERTEX_COUNT);
	localparam int COL_W        = $clog2(COLOR_COUNT);

	localparam int VIN_W = 16;
	localparam int CIN_W = 10;
	localparam int ID_W  = 32;
	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Tag per table entry; an entry is used when its tag equals the epoch
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		STATUS_MATCHED     = 3'd0,
		STATUS_COLOUR_USED = 3'd1,
		STATUS_ENDPOINT    = 3'd2,
		STATUS_LOOP        = 3'd3,
		STATUS_CLEARED     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_EDGE  = 2'd0,
		KIND_LOOP  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_SWEEP  = 2'd0,
		MODE_SETTLE = 2'd1,
		MODE_RUN    = 2'd2
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic [VTX_W-1:0]  vtx_a;
		logic [VTX_W-1:0]  vtx_b;
		logic [COL_W-1:0]  col;
		logic [ID_W-1:0]   edge_id;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### src/greedy_rainbow_matching.sv
// An input passes the front register, queue and back-end register to out_valid.
// Throughput: one item per cycle unless a stall or sweep holds it; a matched
// edge holds the back end for its second write on the single vertex write port.
// Reset: queue and result register empty, count zero; a clearing pass over
// every table entry, then a settle state, runs before the first item is processed.
// The same pass runs again after every 255th clear command.
// ----------------------------------------------------------------------------
// greedy_rainbow_matching
// Greedy maximal rainbow matching over a stream of coloured edges.
// ----------------------------------------------------------------------------
module greedy_rainbow_matching import grm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [VIN_W-1:0]  vertex_a,
	input  logic [VIN_W-1:0]  vertex_b,
	input  logic [CIN_W-1:0]  colour,
	input  logic [ID_W-1:0]   edge_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  match_count,
	output logic [ID_W-1:0]   edge_echo
);

	q_stat_t qs;
	logic    push;
	item_t   push_item;
	logic    pop;
	item_t   head;

	grm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.vertex_a  (vertex_a),
		.vertex_b  (vertex_b),
		.colour    (colour),
		.edge_id   (edge_id),
		.qs        (qs),
		.push      (push),
		.push_item (push_item)
	);

	grm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qs        (qs)
	);

	grm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qs          (qs),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.match_count (match_count),
		.edge_echo   (edge_echo)
	);

endmodule

### src/grm_front.sv
// ----------------------------------------------------------------------------
// grm_front
// Input stage: takes edges and commands, reduces indices and classifies them.
// ----------------------------------------------------------------------------
module grm_front import grm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [VIN_W-1:0]  vertex_a,
	input  logic [VIN_W-1:0]  vertex_b,
	input  logic [CIN_W-1:0]  colour,
	input  logic [ID_W-1:0]   edge_id,
	input  q_stat_t           qs,
	output logic              push,
	output item_t             push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_new;
	logic  take;

	always_comb begin
		item_new.vtx_a   = vertex_a[VTX_W-1:0];
		item_new.vtx_b   = vertex_b[VTX_W-1:0];
		item_new.col     = colour[COL_W-1:0];
		item_new.edge_id = edge_id;
		if (command) begin
			item_new.kind = KIND_CLEAR;
		end else if (vertex_a[VTX_W-1:0] == vertex_b[VTX_W-1:0]) begin
			item_new.kind = KIND_LOOP;
		end else begin
			item_new.kind = KIND_EDGE;
		end
	end

	assign push      = valid_s1 && !qs.full;
	assign in_stall  = valid_s1 && qs.full;
	assign take      = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_new;
		end
	end

endmodule

### src/grm_queue.sv
// ----------------------------------------------------------------------------
// grm_queue
// Short FIFO between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module grm_queue import grm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t qs
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head     = mem_q[rd_ptr_q];
	assign qs.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qs.empty = (fill_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### src/grm_back.sv
// ----------------------------------------------------------------------------
// grm_back
// Tag tables, match decision, forwarding and the result register.
// ----------------------------------------------------------------------------
module grm_back import grm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             head,
	input  q_stat_t           qs,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  match_count,
	output logic [ID_W-1:0]   edge_echo
);

	// Tag memories
	logic [EPOCH_W-1:0] vtx_mem [VERTEX_COUNT];
	logic [EPOCH_W-1:0] col_mem [COLOR_COUNT];
	logic [EPOCH_W-1:0] va_rd_q;
	logic [EPOCH_W-1:0] vb_rd_q;
	logic [EPOCH_W-1:0] col_rd_q;

	mode_t              mode_q;
	mode_t              mode_d;
	logic [VTX_W-1:0]   sweep_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   count_q;

	logic               valid_s2;
	item_t              item_s2;

	// Second vertex write of a matched edge goes out in the next cycle, from pend_q
	logic               pend_q;
	logic [VTX_W-1:0]   pend_addr_q;
	logic               fwd_q;
	logic [VTX_W-1:0]   fwd_addr_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [CNT_W-1:0]   count_out_q;
	logic [ID_W-1:0]    echo_q;

	logic               fire;
	logic               load_s2;
	item_t              rd_item;
	logic               col_used;
	logic               vtx_used;
	status_t            verdict;
	logic               accept;
	logic               clear;
	logic               vw_en;
	logic [VTX_W-1:0]   vw_addr;
	logic [EPOCH_W-1:0] vw_tag;
	logic               cw_en;
	logic [COL_W-1:0]   cw_addr;
	logic [EPOCH_W-1:0] cw_tag;

	assign fire    = valid_s2 && (mode_q == MODE_RUN) && !pend_q
	                 && (!out_valid_q || !out_stall);
	assign load_s2 = !qs.empty && (!valid_s2 || fire);
	assign pop     = load_s2;
	// Re-read a held item every cycle so its tags track the latest writes
	assign rd_item = load_s2 ? head : item_s2;

	assign col_used = (col_rd_q == epoch_q);
	assign vtx_used = (va_rd_q == epoch_q) || (vb_rd_q == epoch_q)
	                  || (fwd_q && (fwd_addr_q == item_s2.vtx_a))
	                  || (fwd_q && (fwd_addr_q == item_s2.vtx_b));

	always_comb begin
		case (item_s2.kind)
			KIND_CLEAR: verdict = STATUS_CLEARED;
			KIND_LOOP:  verdict = STATUS_LOOP;
			KIND_EDGE: begin
				if (col_used) begin
					verdict = STATUS_COLOUR_USED;
				end else if (vtx_used) begin
					verdict = STATUS_ENDPOINT;
				end else begin
					verdict = STATUS_MATCHED;
				end
			end
			default:    verdict = STATUS_LOOP;
		endcase
	end

	assign accept = fire && (verdict == STATUS_MATCHED);
	assign clear  = fire && (verdict == STATUS_CLEARED);

	always_comb begin
		vw_en   = 1'b0;
		vw_addr = item_s2.vtx_a;
		vw_tag  = epoch_q;
		cw_en   = 1'b0;
		cw_addr = item_s2.col;
		cw_tag  = epoch_q;
		if (mode_q == MODE_SWEEP) begin
			vw_en   = 1'b1;
			vw_addr = sweep_q;
			vw_tag  = EPOCH_NONE;
			cw_en   = 1'b1;
			cw_addr = sweep_q[COL_W-1:0];
			cw_tag  = EPOCH_NONE;
		end else if (pend_q) begin
			vw_en   = 1'b1;
			vw_addr = pend_addr_q;
		end else if (accept) begin
			vw_en = 1'b1;
			cw_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vw_en) begin
			vtx_mem[vw_addr] <= vw_tag;
		end
		va_rd_q <= vtx_mem[rd_item.vtx_a];
		vb_rd_q <= vtx_mem[rd_item.vtx_b];
	end

	always_ff @(posedge clk) begin
		if (cw_en) begin
			col_mem[cw_addr] <= cw_tag;
		end
		col_rd_q <= col_mem[rd_item.col];
	end

	// Sweep the tables after reset and whenever the epoch runs out
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_SWEEP: begin
				if (sweep_q == '1) begin
					mode_d = MODE_SETTLE;
				end
			end
			MODE_SETTLE: mode_d = MODE_RUN;
			MODE_RUN: begin
				if (clear && (epoch_q == EPOCH_LAST)) begin
					mode_d = MODE_SWEEP;
				end
			end
			default: mode_d = MODE_SWEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SWEEP;
			sweep_q <= '0;
			epoch_q <= EPOCH_FIRST;
		end else begin
			mode_q <= mode_d;
			if (mode_q == MODE_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (clear) begin
				epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			pend_q      <= 1'b0;
			fwd_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			pend_q <= accept;
			fwd_q  <= pend_q;
			if (clear) begin
				count_q <= '0;
			end else if (accept && (count_q != CNT_MAX)) begin
				count_q <= count_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2 <= head;
		end
		if (accept) begin
			pend_addr_q <= item_s2.vtx_b;
		end
		fwd_addr_q <= pend_addr_q;
		if (fire) begin
			status_q <= verdict;
			echo_q   <= item_s2.edge_id;
			if (clear) begin
				count_out_q <= '0;
			end else if (accept && (count_q != CNT_MAX)) begin
				count_out_q <= count_q + 1'b1;
			end else begin
				count_out_q <= count_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_count = count_out_q;
	assign edge_echo   = echo_q;

endmodule

### src/grm_checker.sv
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks on the result channel of the matching block.
// ----------------------------------------------------------------------------
module grm_checker import grm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [2:0]        status,
	input logic [CNT_W-1:0]  match_count,
	input logic [ID_W-1:0]   edge_echo
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
		&& $stable(match_count) && $stable(edge_echo))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_MATCHED) || (status == STATUS_COLOUR_USED)
		|| (status == STATUS_ENDPOINT) || (status == STATUS_LOOP)
		|| (status == STATUS_CLEARED))
		else $error("status code out of range");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_CLEARED) |-> (match_count == '0))
		else $error("clear result with nonzero count");

	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_MATCHED) |-> (match_count != '0))
		else $error("matched result with zero count");

endmodule

bind greedy_rainbow_matching grm_checker u_grm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.match_count (match_count),
	.edge_echo   (edge_echo)
);
